[sv/utf8t_pkg.sv]
// Shared types and constants for the UTF-8 code point transcoder.
// No dependencies; every other file of the block imports this package.
package utf8t_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_BYTES = 6;
  localparam int unsigned CP_IN_W   = 32;
  localparam int unsigned CP_OUT_W  = 31;
  localparam int unsigned CNT_W     = 3;

  typedef logic [BYTE_W-1:0]                 byte_t;
  typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] byte_vec_t;
  typedef logic [CP_IN_W-1:0]                cp_in_t;
  typedef logic [CP_OUT_W-1:0]               cp_out_t;
  typedef logic [CNT_W-1:0]                  cnt_t;

  typedef enum logic {
    REQ_DECODE = 1'b0,
    REQ_ENCODE = 1'b1
  } req_type_t;

  // Sequence length; the numeric value is the byte count.
  typedef enum logic [CNT_W-1:0] {
    LEN_NONE = 3'd0,
    LEN_1    = 3'd1,
    LEN_2    = 3'd2,
    LEN_3    = 3'd3,
    LEN_4    = 3'd4,
    LEN_5    = 3'd5,
    LEN_6    = 3'd6
  } len_t;

  // Largest byte accepted as a continuation byte, and the continuation tag.
  localparam byte_t     CONT_MAX = 8'hBF;
  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef struct packed {
    req_type_t req_type;
    byte_vec_t in_bytes;
    cp_in_t    code_point;
  } req_t;

  typedef struct packed {
    cp_out_t   code_point;
    byte_vec_t out_bytes;
    cnt_t      byte_count;
    logic      seq_valid;
  } rsp_t;

endpackage

[sv/utf8t_if.sv]
// Valid/ready channel interfaces for the transcoder's request and result items.
// Depends on utf8t_pkg for field types.
interface utf8t_req_if import utf8t_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      req_type;
  byte_t     in_byte0;
  byte_t     in_byte1;
  byte_t     in_byte2;
  byte_t     in_byte3;
  byte_t     in_byte4;
  byte_t     in_byte5;
  cp_in_t    code_point_in;

  modport source (output valid, req_type, in_byte0, in_byte1, in_byte2, in_byte3,
                  in_byte4, in_byte5, code_point_in, input ready);
  modport sink   (input valid, req_type, in_byte0, in_byte1, in_byte2, in_byte3,
                  in_byte4, in_byte5, code_point_in, output ready);
endinterface

interface utf8t_rsp_if import utf8t_pkg::*; ();
  logic      valid;
  logic      ready;
  cp_out_t   code_point_out;
  byte_t     out_byte0;
  byte_t     out_byte1;
  byte_t     out_byte2;
  byte_t     out_byte3;
  byte_t     out_byte4;
  byte_t     out_byte5;
  cnt_t      byte_count;
  logic      seq_valid;

  modport source (output valid, code_point_out, out_byte0, out_byte1, out_byte2,
                  out_byte3, out_byte4, out_byte5, byte_count, seq_valid,
                  input ready);
  modport sink   (input valid, code_point_out, out_byte0, out_byte1, out_byte2,
                  out_byte3, out_byte4, out_byte5, byte_count, seq_valid,
                  output ready);
endinterface

[sv/utf8_code_point_transcoder_unit.sv]
// Top level of the UTF-8 code point transcoder: request register, decoder and
// encoder logic, result register. Depends on utf8t_pkg, utf8t_if,
// utf8t_decode and utf8t_encode.
//
// Each request item either decodes up to six UTF-8 bytes into a code point or
// encodes a code point into one to six UTF-8 bytes, and yields exactly one
// result item. The block accepts one item per clock while the output side is
// not stalled and delivers results in order; an accepted item is held in the
// request register, and its result is captured in the result register and
// offered from there, with the decode and encode logic between the two
// registers. When the output stalls, both registers fill and the block can
// hold two items before it lowers in_req.ready.
module utf8_code_point_transcoder_unit import utf8t_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  utf8t_req_if.sink   in_req,
  utf8t_rsp_if.source out_rsp
);

  logic req_v_r;
  req_t req_r;
  logic rsp_v_r;
  rsp_t rsp_r;

  logic stage1_adv;
  logic in_take;
  req_t req_nxt;
  rsp_t rsp_nxt;
  rsp_t dec_rsp;
  rsp_t enc_rsp;

  assign stage1_adv   = !rsp_v_r || out_rsp.ready;
  assign in_req.ready = !req_v_r || stage1_adv;
  assign in_take      = in_req.valid && in_req.ready;

  always_comb begin
    req_nxt.req_type   = req_type_t'(in_req.req_type);
    req_nxt.in_bytes   = {in_req.in_byte5, in_req.in_byte4, in_req.in_byte3,
                          in_req.in_byte2, in_req.in_byte1, in_req.in_byte0};
    req_nxt.code_point = in_req.code_point_in;
  end

  utf8t_decode u_decode (
    .in_bytes (req_r.in_bytes),
    .rsp      (dec_rsp)
  );

  utf8t_encode u_encode (
    .code_point (req_r.code_point),
    .rsp        (enc_rsp)
  );

  assign rsp_nxt = (req_r.req_type == REQ_ENCODE) ? enc_rsp : dec_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      rsp_v_r <= 1'b0;
    end else begin
      if (in_req.ready) begin
        req_v_r <= in_req.valid;
      end
      if (stage1_adv) begin
        rsp_v_r <= req_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= req_nxt;
    end
    if (stage1_adv && req_v_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid          = rsp_v_r;
  assign out_rsp.code_point_out = rsp_r.code_point;
  assign out_rsp.out_byte0      = rsp_r.out_bytes[0];
  assign out_rsp.out_byte1      = rsp_r.out_bytes[1];
  assign out_rsp.out_byte2      = rsp_r.out_bytes[2];
  assign out_rsp.out_byte3      = rsp_r.out_bytes[3];
  assign out_rsp.out_byte4      = rsp_r.out_bytes[4];
  assign out_rsp.out_byte5      = rsp_r.out_bytes[5];
  assign out_rsp.byte_count     = rsp_r.byte_count;
  assign out_rsp.seq_valid      = rsp_r.seq_valid;

endmodule

[sv/utf8t_decode.sv]
// UTF-8 to code point decoder: sizes the sequence from the lead byte,
// assembles the code point and checks continuation and terminator bytes.
// Depends on utf8t_pkg.
module utf8t_decode import utf8t_pkg::*; (
  input  byte_vec_t in_bytes,
  output rsp_t      rsp
);

  byte_t                lead;
  len_t                 len;
  logic [NUM_BYTES-1:0] cont_ok;
  cp_out_t              cp;
  logic                 ok;

  assign lead = in_bytes[0];

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      cont_ok[i] = (in_bytes[i] <= CONT_MAX);
    end
  end

  // Bytes from 0x80 to 0xBF fall into the two-byte class as lead bytes.
  always_comb begin
    priority if (lead <= 8'h7F) len = LEN_1;
    else if (lead <= 8'hDF) len = LEN_2;
    else if (lead <= 8'hEF) len = LEN_3;
    else if (lead <= 8'hF7) len = LEN_4;
    else if (lead <= 8'hFB) len = LEN_5;
    else if (lead <= 8'hFD) len = LEN_6;
    else len = LEN_NONE;
  end

  always_comb begin
    cp = '0;
    ok = 1'b0;
    unique case (len)
      LEN_1: begin
        cp = CP_OUT_W'(lead[6:0]);
        ok = 1'b1;
      end
      LEN_2: begin
        cp = CP_OUT_W'({lead[4:0], in_bytes[1][5:0]});
        ok = cont_ok[1] && (in_bytes[2] == '0);
      end
      LEN_3: begin
        cp = CP_OUT_W'({lead[3:0], in_bytes[1][5:0], in_bytes[2][5:0]});
        ok = (&cont_ok[2:1]) && (in_bytes[3] == '0);
      end
      LEN_4: begin
        cp = CP_OUT_W'({lead[2:0], in_bytes[1][5:0], in_bytes[2][5:0],
                        in_bytes[3][5:0]});
        ok = (&cont_ok[3:1]) && (in_bytes[4] == '0);
      end
      LEN_5: begin
        cp = CP_OUT_W'({lead[1:0], in_bytes[1][5:0], in_bytes[2][5:0],
                        in_bytes[3][5:0], in_bytes[4][5:0]});
        ok = (&cont_ok[4:1]) && (in_bytes[5] == '0);
      end
      LEN_6: begin
        // Six-byte sequences have no terminator byte to check.
        cp = {lead[0], in_bytes[1][5:0], in_bytes[2][5:0], in_bytes[3][5:0],
              in_bytes[4][5:0], in_bytes[5][5:0]};
        ok = &cont_ok[5:1];
      end
      default: begin
        cp = '0;
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp            = '0;
    rsp.code_point = cp;
    rsp.byte_count = cnt_t'(len);
    rsp.seq_valid  = ok;
  end

endmodule

[sv/utf8t_encode.sv]
// Code point to UTF-8 encoder producing the shortest form of one to six bytes.
// Depends on utf8t_pkg.
module utf8t_encode import utf8t_pkg::*; (
  input  cp_in_t code_point,
  output rsp_t   rsp
);

  len_t      len;
  byte_vec_t b;

  always_comb begin
    priority if (code_point[31:7] == '0) len = LEN_1;
    else if (code_point[31:11] == '0) len = LEN_2;
    else if (code_point[31:16] == '0) len = LEN_3;
    else if (code_point[31:21] == '0) len = LEN_4;
    else if (code_point[31:26] == '0) len = LEN_5;
    else if (!code_point[31]) len = LEN_6;
    else len = LEN_NONE;
  end

  // The last byte always carries the low six bits; earlier bytes carry
  // successively higher groups, and the lead byte takes what is left.
  always_comb begin
    b = '0;
    unique case (len)
      LEN_1: begin
        b[0] = {1'b0, code_point[6:0]};
      end
      LEN_2: begin
        b[0] = {3'b110, code_point[10:6]};
        b[1] = {CONT_TAG, code_point[5:0]};
      end
      LEN_3: begin
        b[0] = {4'b1110, code_point[15:12]};
        b[1] = {CONT_TAG, code_point[11:6]};
        b[2] = {CONT_TAG, code_point[5:0]};
      end
      LEN_4: begin
        b[0] = {5'b11110, code_point[20:18]};
        b[1] = {CONT_TAG, code_point[17:12]};
        b[2] = {CONT_TAG, code_point[11:6]};
        b[3] = {CONT_TAG, code_point[5:0]};
      end
      LEN_5: begin
        b[0] = {6'b111110, code_point[25:24]};
        b[1] = {CONT_TAG, code_point[23:18]};
        b[2] = {CONT_TAG, code_point[17:12]};
        b[3] = {CONT_TAG, code_point[11:6]};
        b[4] = {CONT_TAG, code_point[5:0]};
      end
      LEN_6: begin
        b[0] = {7'b1111110, code_point[30]};
        b[1] = {CONT_TAG, code_point[29:24]};
        b[2] = {CONT_TAG, code_point[23:18]};
        b[3] = {CONT_TAG, code_point[17:12]};
        b[4] = {CONT_TAG, code_point[11:6]};
        b[5] = {CONT_TAG, code_point[5:0]};
      end
      default: begin
        b = '0;
      end
    endcase
  end

  always_comb begin
    rsp            = '0;
    rsp.out_bytes  = b;
    rsp.byte_count = cnt_t'(len);
    rsp.seq_valid  = (len != LEN_NONE);
  end

endmodule

[sv/utf8t_checker.sv]
// Port-level checker for the UTF-8 code point transcoder, bound to the top.
// Depends on utf8t_pkg.
module utf8t_checker import utf8t_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input cp_out_t code_point_out,
  input byte_t   out_byte0,
  input byte_t   out_byte1,
  input byte_t   out_byte2,
  input byte_t   out_byte3,
  input byte_t   out_byte4,
  input byte_t   out_byte5,
  input cnt_t    byte_count,
  input logic    seq_valid
);

  // A stalled result must stay offered, with its code point, first and last bytes, byte count and validity unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point_out) &&
      $stable(out_byte0) && $stable(out_byte5) && $stable(byte_count) &&
      $stable(seq_valid))
    else $error("stalled result changed or was dropped");

  // A decoded code point never comes with encoded bytes.
  a_dec_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (code_point_out != '0) |->
      (out_byte0 == '0) && (out_byte1 == '0) && (out_byte2 == '0) &&
      (out_byte3 == '0) && (out_byte4 == '0) && (out_byte5 == '0))
    else $error("decode result carries encoded bytes");

  // Nonzero encoded bytes only come from a successful encode.
  a_enc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte0 != '0) |-> seq_valid && (byte_count != '0))
    else $error("encoded bytes without a valid length");

  // An unsized sequence yields nothing.
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (byte_count == '0) |->
      !seq_valid && (code_point_out == '0) && (out_byte0 == '0))
    else $error("zero-length result carries data");

endmodule

bind utf8_code_point_transcoder_unit utf8t_checker u_utf8t_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .code_point_out (out_rsp.code_point_out),
  .out_byte0      (out_rsp.out_byte0),
  .out_byte1      (out_rsp.out_byte1),
  .out_byte2      (out_rsp.out_byte2),
  .out_byte3      (out_rsp.out_byte3),
  .out_byte4      (out_rsp.out_byte4),
  .out_byte5      (out_rsp.out_byte5),
  .byte_count     (out_rsp.byte_count),
  .seq_valid      (out_rsp.seq_valid)
);
